### design/spectral_power_integrator_defines.svh
// Assertion macros shared by the spectral power integrator.
`ifndef SPECTRAL_POWER_INTEGRATOR_DEFINES_SVH
`define SPECTRAL_POWER_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spi: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spi: next-cycle check failed");

`endif

### design/spi_pkg.sv
`default_nettype none

package spi_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int POS_W     = 12;
  localparam int MEAN_W    = 32;
  localparam int SUM_W     = 52;
  localparam int LEN_W     = 13;
  localparam int ILEN_W    = 21;
  localparam int DONE_W    = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 21;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd1024;
  localparam logic [ILEN_W-1:0] ILEN_RESET = 21'd1024;
  localparam logic [ILEN_W-1:0] INTEG_MAX  = 21'd1048576;

  // Item kinds carried in the mode field.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_ARM    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPECTRUM_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATION_LENGTH = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  bin_index;
    logic [MEAN_W-1:0] power_mean;
    logic              last_bin;
  } out_t;

endpackage

`default_nettype wire

### design/spi_sum_mem.sv
`default_nettype none

// Per-bin sum store: one write port, one read port with registered data.
module spi_sum_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [spi_pkg::SUM_W-1:0]   wdata_i,
  input  wire logic                        re_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  output logic      [spi_pkg::SUM_W-1:0]   rdata_o
);

  logic [spi_pkg::SUM_W-1:0] mem [DEPTH];
  logic [spi_pkg::SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/spi_power.sv
`default_nettype none

// Squares of both sample parts, registered.
module spi_power #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [spi_pkg::SAMPLE_W-1:0] re_i,
  input  wire logic signed [spi_pkg::SAMPLE_W-1:0] im_i,
  output logic             [2*SAMPLE_BITS-1:0]     sq_re_o,
  output logic             [2*SAMPLE_BITS-1:0]     sq_im_o
);

  logic signed [SAMPLE_BITS-1:0]   re_s;
  logic signed [SAMPLE_BITS-1:0]   im_s;
  logic signed [2*SAMPLE_BITS-1:0] prod_re;
  logic signed [2*SAMPLE_BITS-1:0] prod_im;
  logic        [2*SAMPLE_BITS-1:0] sq_re_q;
  logic        [2*SAMPLE_BITS-1:0] sq_im_q;

  // The low SAMPLE_BITS bits are two's complement; a wider sample sees the
  // field zero-extended.
  if (SAMPLE_BITS <= spi_pkg::SAMPLE_W) begin : g_narrow
    assign re_s = re_i[SAMPLE_BITS-1:0];
    assign im_s = im_i[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign re_s = {{(SAMPLE_BITS-spi_pkg::SAMPLE_W){1'b0}}, re_i};
    assign im_s = {{(SAMPLE_BITS-spi_pkg::SAMPLE_W){1'b0}}, im_i};
  end

  assign prod_re = re_s * re_s;
  assign prod_im = im_s * im_s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_re_q <= prod_re;
      sq_im_q <= prod_im;
    end
  end

  assign sq_re_o = sq_re_q;
  assign sq_im_o = sq_im_q;

endmodule

`default_nettype wire

### design/spi_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module spi_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [spi_pkg::SUM_W-1:0]    dividend_i,
  input  wire logic [spi_pkg::ILEN_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic      [spi_pkg::SUM_W-1:0]    quotient_o
);

  localparam logic [spi_pkg::DIV_CNT_W-1:0] LAST_STEP =
    spi_pkg::DIV_CNT_W'(spi_pkg::SUM_W - 1);

  logic                             busy_q;
  logic [spi_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [spi_pkg::ILEN_W-1:0]       rem_q;
  logic [spi_pkg::ILEN_W-1:0]       dvs_q;
  logic [spi_pkg::SUM_W-1:0]        quo_q;
  logic [spi_pkg::ILEN_W:0]         trial;
  logic [spi_pkg::ILEN_W:0]         diff;

  assign trial = {rem_q, quo_q[spi_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (!diff[spi_pkg::ILEN_W]) begin
        rem_q <= diff[spi_pkg::ILEN_W-1:0];
        quo_q <= {quo_q[spi_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[spi_pkg::ILEN_W-1:0];
        quo_q <= {quo_q[spi_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### design/spectral_power_integrator.sv
// A sample beat in the last spectrum of a capture yields its mean after a write-back step that
// also starts the divider, the divider steps, and one load once the output register has room.
// Throughput: one beat per cycle outside a capture; while accumulating, the next beat waits until
// the write-back is done, and in the last spectrum until the divider has finished and loaded.
// Reset: asynchronous, active low; afterwards a clearing pass over every slot zeroes the
// sum memory, and no input beat is accepted until it completes.
`default_nettype none

`include "spectral_power_integrator_defines.svh"

module spectral_power_integrator #(
  parameter int MAX_BINS    = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [spi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [spi_pkg::CFG_DW-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire spi_pkg::in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output spi_pkg::out_t                         out_data_o
);

  // Address width of the sum memory. The bin position never reaches
  // MAX_BINS, so the memory slot is the position resized to this width.
  localparam int ADDR_W  = $clog2(MAX_BINS);
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  // The spectrum length register cannot exceed its 13-bit range, so the
  // clamp only matters when MAX_BINS is below that range.
  localparam int LEN_CAP = (MAX_BINS < 8191) ? MAX_BINS : 8191;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);

  // The block runs one beat at a time. After the clearing pass it waits in
  // S_IDLE; a sample beat that belongs to a capture reads its bin's sum and
  // moves to S_ACC, where the sum is written back (or zeroed in the last
  // spectrum). A last-spectrum bin then waits in S_DIV for the divider and
  // for room in the output register.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_DIV
  } state_e;

  state_e                          state_q, state_d;
  logic [ADDR_W-1:0]               clr_q, clr_d;
  logic [spi_pkg::LEN_W-1:0]       spec_len_q;
  logic [spi_pkg::ILEN_W-1:0]      integ_len_q;
  logic [spi_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [spi_pkg::DONE_W-1:0]      done_q, done_d;
  logic                            armed_q, armed_d;
  logic                            capturing_q, capturing_d;
  logic [ADDR_W-1:0]               slot_q, slot_d;
  logic [spi_pkg::POS_W-1:0]       bin_q, bin_d;
  logic                            eos_q, eos_d;
  logic                            last_q, last_d;
  logic                            out_valid_q, out_valid_d;
  spi_pkg::out_t                   out_q, out_d;

  logic [spi_pkg::LEN_W-1:0]       len_eff;
  logic [spi_pkg::ILEN_W-1:0]      ilen_eff;
  logic                            in_fire;
  logic                            eos;
  logic                            last_spec;
  logic                            cap_v;
  logic [spi_pkg::DONE_W-1:0]      done_v;
  logic [ADDR_W-1:0]               slot;
  logic                            sq_en;
  logic [SQ_W-1:0]                 sq_re;
  logic [SQ_W-1:0]                 sq_im;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [spi_pkg::SUM_W-1:0]       mem_wdata;
  logic                            mem_re;
  logic [spi_pkg::SUM_W-1:0]       mem_rdata;
  logic [spi_pkg::SUM_W-1:0]       sum;
  logic                            div_start;
  logic                            div_busy;
  logic [spi_pkg::SUM_W-1:0]       div_quo;

  // Out-of-range lengths are clamped to the nearest legal value.
  always_comb begin
    if (spec_len_q == '0) begin
      len_eff = spi_pkg::LEN_W'(1);
    end else if (spec_len_q > spi_pkg::LEN_W'(LEN_CAP)) begin
      len_eff = spi_pkg::LEN_W'(LEN_CAP);
    end else begin
      len_eff = spec_len_q;
    end
    if (integ_len_q == '0) begin
      ilen_eff = spi_pkg::ILEN_W'(1);
    end else if (integ_len_q > spi_pkg::INTEG_MAX) begin
      ilen_eff = spi_pkg::INTEG_MAX;
    end else begin
      ilen_eff = integ_len_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot       = ADDR_W'(pos_q);
  // A position at or past the spectrum end (after a length change) is taken
  // as the last bin, and the position wraps.
  assign eos        = ({1'b0, pos_q} + spi_pkg::LEN_W'(1)) >= len_eff;
  assign sum        = mem_rdata + spi_pkg::SUM_W'(sq_re) + spi_pkg::SUM_W'(sq_im);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    done_d      = done_q;
    armed_d     = armed_q;
    capturing_d = capturing_q;
    slot_d      = slot_q;
    bin_d       = bin_q;
    eos_d       = eos_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cap_v       = capturing_q;
    done_v      = done_q;
    last_spec   = 1'b0;
    sq_en       = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = slot_q;
    mem_wdata   = '0;
    div_start   = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == spi_pkg::MODE_ARM) begin
            // An arm beat only sets the pending flag; it is dropped while a
            // capture is pending or running.
            if (!capturing_q && !armed_q) begin
              armed_d = 1'b1;
            end
          end else begin
            if (pos_q == '0 && armed_q) begin
              armed_d = 1'b0;
              cap_v   = 1'b1;
              done_v  = '0;
            end
            last_spec = ({1'b0, done_v} + spi_pkg::ILEN_W'(1)) >= ilen_eff;
            if (cap_v) begin
              sq_en   = 1'b1;
              mem_re  = 1'b1;
              slot_d  = slot;
              bin_d   = pos_q;
              eos_d   = eos;
              last_d  = last_spec;
              state_d = S_ACC;
              if (last_spec) begin
                if (eos) begin
                  cap_v  = 1'b0;
                  done_v = '0;
                end
              end else if (eos) begin
                done_v = done_v + 1'b1;
              end
            end
            capturing_d = cap_v;
            done_d      = done_v;
            pos_d       = eos ? '0 : pos_q + 1'b1;
          end
        end
      end
      S_ACC: begin
        // Write back the updated sum; the last spectrum clears the bin and
        // hands the sum to the divider.
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = last_q ? '0 : sum;
        if (last_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d      = 1'b1;
          out_d.bin_index  = bin_q;
          out_d.power_mean = div_quo[spi_pkg::MEAN_W-1:0];
          out_d.last_bin   = eos_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      spec_len_q  <= spi_pkg::LEN_RESET;
      integ_len_q <= spi_pkg::ILEN_RESET;
      pos_q       <= '0;
      done_q      <= '0;
      armed_q     <= 1'b0;
      capturing_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pos_q       <= pos_d;
      done_q      <= done_d;
      armed_q     <= armed_d;
      capturing_q <= capturing_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          spi_pkg::REG_SPECTRUM_LENGTH: begin
            spec_len_q <= cfg_data_i[spi_pkg::LEN_W-1:0];
          end
          spi_pkg::REG_INTEGRATION_LENGTH: begin
            integ_len_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    bin_q  <= bin_d;
    eos_q  <= eos_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  spi_sum_mem #(
    .DEPTH  (MAX_BINS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot),
    .rdata_o (mem_rdata)
  );

  spi_power #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_power (
    .clk_i   (clk_i),
    .en_i    (sq_en),
    .re_i    (in_data_i.sample_re),
    .im_i    (in_data_i.sample_im),
    .sq_re_o (sq_re),
    .sq_im_o (sq_im)
  );

  spi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (ilen_eff),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A pending arm and a running capture exclude each other.
  `SPI_ASSERT_IMP(a_arm_excl, clk_i, rst_ni, 1'b1, !(armed_q && capturing_q))
  // The block only takes a new beat once the divider has finished.
  `SPI_ASSERT_IMP(a_ready_div_idle, clk_i, rst_ni, in_ready_o, !div_busy)
  // No result can exist while the sum memory is being cleared.
  `SPI_ASSERT_IMP(a_clear_no_out, clk_i, rst_ni, state_q == S_CLEAR, !out_valid_q)
  // A divider start is always taken up by the divider.
  `SPI_ASSERT_NXT(a_div_start, clk_i, rst_ni, div_start, div_busy)

endmodule

`default_nettype wire
